>>> design/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants for the two-class priority server queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int FAULT_DEPTH     = 16;
    localparam int TELEMETRY_DEPTH = 16;

    localparam int FAULT_AW = (FAULT_DEPTH > 1) ? $clog2(FAULT_DEPTH) : 1;
    localparam int TELEM_AW = (TELEMETRY_DEPTH > 1) ? $clog2(TELEMETRY_DEPTH) : 1;
    localparam int FAULT_CW = $clog2(FAULT_DEPTH + 1);
    localparam int TELEM_CW = $clog2(TELEMETRY_DEPTH + 1);

    // width that holds the sum of both queue lengths and at least seven bits
    localparam int QMAX_CW = (FAULT_CW > TELEM_CW) ? FAULT_CW : TELEM_CW;
    localparam int QSUM_W  = (QMAX_CW + 1 > 7) ? QMAX_CW + 1 : 7;

    localparam logic [5:0] PEAK_MAX = 6'h3f;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_DONE    = 1'b1;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] ptime;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic        req_type;
        logic        pkt_is_fault;
        logic [15:0] pkt_tag;
        logic [31:0] pkt_time;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic        started;
        logic [15:0] started_tag;
        logic        started_is_fault;
        logic        busy_res;
        logic        dropped;
        logic [4:0]  fault_len;
        logic [4:0]  telemetry_len;
        logic [31:0] served_total;
        logic [31:0] served_fault;
        logic [31:0] served_telemetry;
        logic [47:0] fault_delay_sum;
        logic [5:0]  max_waiting;
    } t_out_item;

endpackage

>>> design/tcpq_regfile.sv
// ----------------------------------------------------------------------------
// tcpq_regfile
// Small register file: one write port, one asynchronous read port.
// ----------------------------------------------------------------------------
module tcpq_regfile #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[i_raddr];

endmodule

>>> design/tcpq_core.sv
// ----------------------------------------------------------------------------
// tcpq_core
// Server state, class queues and counters; computes one result per item.
// ----------------------------------------------------------------------------
module tcpq_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  tcpq_pkg::t_in_item  i_item,
    output tcpq_pkg::t_out_item o_result
);

    logic [tcpq_pkg::FAULT_AW-1:0] r_f_head, n_f_head;
    logic [tcpq_pkg::FAULT_CW-1:0] r_f_count, n_f_count;
    logic [tcpq_pkg::TELEM_AW-1:0] r_t_head, n_t_head;
    logic [tcpq_pkg::TELEM_CW-1:0] r_t_count, n_t_count;
    logic        r_busy, n_busy;
    logic        r_cur_fault, n_cur_fault;
    logic [15:0] r_cur_tag, n_cur_tag;
    logic [31:0] r_cur_time, n_cur_time;
    logic [31:0] r_srv_total, n_srv_total;
    logic [31:0] r_srv_fault, n_srv_fault;
    logic [31:0] r_srv_telem, n_srv_telem;
    logic [47:0] r_delay_sum, n_delay_sum;
    logic [5:0]  r_peak, n_peak;

    logic                          f_push, t_push, f_pop, t_pop;
    logic [tcpq_pkg::FAULT_AW-1:0] f_tail;
    logic [tcpq_pkg::TELEM_AW-1:0] t_tail;
    logic [tcpq_pkg::QSUM_W-1:0]   f_tail_sum, t_tail_sum;
    tcpq_pkg::t_entry              wr_entry, f_rd_entry, t_rd_entry;
    logic [tcpq_pkg::QSUM_W-1:0]   f_len_ext, t_len_ext, total;
    logic [31:0]                   delay;
    logic [48:0]                   delay_add;
    logic                          started, dropped;

    assign wr_entry.tag   = i_item.pkt_tag;
    assign wr_entry.ptime = i_item.pkt_time;

    // tail = head + count, wrapped
    always_comb begin
        f_tail_sum = tcpq_pkg::QSUM_W'(r_f_head) + tcpq_pkg::QSUM_W'(r_f_count);
        if (f_tail_sum >= tcpq_pkg::QSUM_W'(tcpq_pkg::FAULT_DEPTH)) begin
            f_tail_sum = f_tail_sum - tcpq_pkg::QSUM_W'(tcpq_pkg::FAULT_DEPTH);
        end
        f_tail = f_tail_sum[tcpq_pkg::FAULT_AW-1:0];
        t_tail_sum = tcpq_pkg::QSUM_W'(r_t_head) + tcpq_pkg::QSUM_W'(r_t_count);
        if (t_tail_sum >= tcpq_pkg::QSUM_W'(tcpq_pkg::TELEMETRY_DEPTH)) begin
            t_tail_sum = t_tail_sum - tcpq_pkg::QSUM_W'(tcpq_pkg::TELEMETRY_DEPTH);
        end
        t_tail = t_tail_sum[tcpq_pkg::TELEM_AW-1:0];
    end

    tcpq_regfile #(
        .DEPTH (tcpq_pkg::FAULT_DEPTH),
        .WIDTH (tcpq_pkg::ENTRY_W),
        .AW    (tcpq_pkg::FAULT_AW)
    ) u_fault_q (
        .i_clk   (i_clk),
        .i_we    (i_fire && f_push),
        .i_waddr (f_tail),
        .i_wdata (wr_entry),
        .i_raddr (r_f_head),
        .o_rdata (f_rd_entry)
    );

    tcpq_regfile #(
        .DEPTH (tcpq_pkg::TELEMETRY_DEPTH),
        .WIDTH (tcpq_pkg::ENTRY_W),
        .AW    (tcpq_pkg::TELEM_AW)
    ) u_telem_q (
        .i_clk   (i_clk),
        .i_we    (i_fire && t_push),
        .i_waddr (t_tail),
        .i_wdata (wr_entry),
        .i_raddr (r_t_head),
        .o_rdata (t_rd_entry)
    );

    assign delay     = i_item.now - r_cur_time;
    assign delay_add = {1'b0, r_delay_sum} + 49'(delay);

    always_comb begin
        n_f_head    = r_f_head;
        n_f_count   = r_f_count;
        n_t_head    = r_t_head;
        n_t_count   = r_t_count;
        n_busy      = r_busy;
        n_cur_fault = r_cur_fault;
        n_cur_tag   = r_cur_tag;
        n_cur_time  = r_cur_time;
        n_srv_total = r_srv_total;
        n_srv_fault = r_srv_fault;
        n_srv_telem = r_srv_telem;
        n_delay_sum = r_delay_sum;
        n_peak      = r_peak;
        f_push      = 1'b0;
        t_push      = 1'b0;
        f_pop       = 1'b0;
        t_pop       = 1'b0;
        started     = 1'b0;
        dropped     = 1'b0;

        if (i_item.req_type == tcpq_pkg::REQ_ARRIVAL) begin
            if (!r_busy) begin
                n_busy      = 1'b1;
                n_cur_fault = i_item.pkt_is_fault;
                n_cur_tag   = i_item.pkt_tag;
                n_cur_time  = i_item.pkt_time;
                started     = 1'b1;
            end else if (i_item.pkt_is_fault) begin
                if (r_f_count != tcpq_pkg::FAULT_CW'(tcpq_pkg::FAULT_DEPTH)) begin
                    f_push    = 1'b1;
                    n_f_count = r_f_count + 1'b1;
                end else begin
                    dropped = 1'b1;
                end
            end else begin
                if (r_t_count != tcpq_pkg::TELEM_CW'(tcpq_pkg::TELEMETRY_DEPTH)) begin
                    t_push    = 1'b1;
                    n_t_count = r_t_count + 1'b1;
                end else begin
                    dropped = 1'b1;
                end
            end
        end else if (r_busy) begin
            if (r_srv_total != 32'hffff_ffff) begin
                n_srv_total = r_srv_total + 1'b1;
            end
            if (r_cur_fault) begin
                if (r_srv_fault != 32'hffff_ffff) begin
                    n_srv_fault = r_srv_fault + 1'b1;
                end
                n_delay_sum = delay_add[48] ? 48'hffff_ffff_ffff : delay_add[47:0];
            end else if (r_srv_telem != 32'hffff_ffff) begin
                n_srv_telem = r_srv_telem + 1'b1;
            end
            if (r_f_count != '0) begin
                f_pop       = 1'b1;
                n_cur_fault = 1'b1;
                n_cur_tag   = f_rd_entry.tag;
                n_cur_time  = f_rd_entry.ptime;
                n_f_count   = r_f_count - 1'b1;
                started     = 1'b1;
            end else if (r_t_count != '0) begin
                t_pop       = 1'b1;
                n_cur_fault = 1'b0;
                n_cur_tag   = t_rd_entry.tag;
                n_cur_time  = t_rd_entry.ptime;
                n_t_count   = r_t_count - 1'b1;
                started     = 1'b1;
            end else begin
                n_busy      = 1'b0;
                n_cur_fault = 1'b0;
                n_cur_tag   = '0;
                n_cur_time  = '0;
            end
        end

        if (f_pop) begin
            n_f_head = (r_f_head == tcpq_pkg::FAULT_AW'(tcpq_pkg::FAULT_DEPTH - 1)) ?
                       '0 : r_f_head + 1'b1;
        end
        if (t_pop) begin
            n_t_head = (r_t_head == tcpq_pkg::TELEM_AW'(tcpq_pkg::TELEMETRY_DEPTH - 1)) ?
                       '0 : r_t_head + 1'b1;
        end

        f_len_ext = tcpq_pkg::QSUM_W'(n_f_count);
        t_len_ext = tcpq_pkg::QSUM_W'(n_t_count);
        total     = f_len_ext + t_len_ext;
        if (f_push || t_push) begin
            if (total > tcpq_pkg::QSUM_W'(tcpq_pkg::PEAK_MAX)) begin
                n_peak = tcpq_pkg::PEAK_MAX;
            end else if (total[5:0] > r_peak) begin
                n_peak = total[5:0];
            end
        end
    end

    always_comb begin
        o_result.started          = started;
        o_result.started_tag      = started ? n_cur_tag : '0;
        o_result.started_is_fault = started ? n_cur_fault : 1'b0;
        o_result.busy_res         = n_busy;
        o_result.dropped          = dropped;
        o_result.fault_len        = f_len_ext[4:0];
        o_result.telemetry_len    = t_len_ext[4:0];
        o_result.served_total     = n_srv_total;
        o_result.served_fault     = n_srv_fault;
        o_result.served_telemetry = n_srv_telem;
        o_result.fault_delay_sum  = n_delay_sum;
        o_result.max_waiting      = n_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_head    <= '0;
            r_f_count   <= '0;
            r_t_head    <= '0;
            r_t_count   <= '0;
            r_busy      <= 1'b0;
            r_cur_fault <= 1'b0;
            r_cur_tag   <= '0;
            r_cur_time  <= '0;
            r_srv_total <= '0;
            r_srv_fault <= '0;
            r_srv_telem <= '0;
            r_delay_sum <= '0;
            r_peak      <= '0;
        end else if (i_fire) begin
            r_f_head    <= n_f_head;
            r_f_count   <= n_f_count;
            r_t_head    <= n_t_head;
            r_t_count   <= n_t_count;
            r_busy      <= n_busy;
            r_cur_fault <= n_cur_fault;
            r_cur_tag   <= n_cur_tag;
            r_cur_time  <= n_cur_time;
            r_srv_total <= n_srv_total;
            r_srv_fault <= n_srv_fault;
            r_srv_telem <= n_srv_telem;
            r_delay_sum <= n_delay_sum;
            r_peak      <= n_peak;
        end
    end

endmodule

>>> design/two_class_priority_server_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_server_queue
// Single server with strict-priority fault and telemetry queues.
//
// Input channel (i_in_valid / o_in_ready / i_in_item): one item per transfer,
// either a packet arrival or a service-done event for the packet in service.
// Output channel (o_out_valid / i_out_ready / o_out_item): exactly one result
// per input item, in order, with the start, drop and queue status plus the
// served counters, fault delay sum and peak waiting count.
// Path: an item taken into the input register has its result written to the
// output register when it advances; a receiver stall can hold it in between.
// Throughput: one item per cycle while the receiver takes results; the whole
// state update (enqueue or dequeue, priority select, counter and 48-bit delay
// add) sits between the input register and the result register.
// Reset (synchronous, active low): both queues empty, server idle, counters,
// delay sum and peak cleared, both pipeline registers empty.
// Receiver stall: the result register holds; the input register still takes
// one more item, then o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module two_class_priority_server_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcpq_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    tcpq_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    tcpq_pkg::t_out_item r_out_item;
    tcpq_pkg::t_out_item result;
    logic                advance;
    logic                fire;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    tcpq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/tcpq_checker.sv
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks for the two-class priority server queue.
// ----------------------------------------------------------------------------
module tcpq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input tcpq_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tcpq_pkg::t_out_item o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // a started packet leaves the server busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.started |-> o_out_item.busy_res && !o_out_item.dropped)
        else $error("start without busy server");

    // drops only happen behind a busy server, with no start fields
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.started |->
            o_out_item.started_tag == 16'h0000 && !o_out_item.started_is_fault &&
            (!o_out_item.dropped || o_out_item.busy_res))
        else $error("bad start fields or drop while idle");

    logic unused_in;
    assign unused_in = i_in_valid ^ (^i_in_item);

endmodule

bind two_class_priority_server_queue tcpq_checker u_tcpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
